>>> design/bda_pkg.sv
// Shared types and constants for the button debounce / auto-repeat block.
// No dependencies; every other design file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none
package bda_pkg;

	localparam int TIME_W    = 32;
	localparam int DEB_W     = 8;
	localparam int HOLD_W    = 8;
	localparam int LVL_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DAT_W = 8;

	localparam logic [DEB_W-1:0]  DEB_RESET   = 8'd5;
	localparam logic [HOLD_W-1:0] HOLD_RESET  = 8'd15;
	localparam logic [LVL_W-1:0]  MAXLV_RESET = 4'd15;
	localparam logic [LVL_W-1:0]  LEVEL_RESET = 4'd1;
	localparam logic [HOLD_W-1:0] HOLD_TOP    = 8'hFF;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEBOUNCE  = 2'd0,
		CFG_HOLD      = 2'd1,
		CFG_MAX_LEVEL = 2'd2
	} cfg_idx_t;

	// per-button events for one poll
	typedef struct packed {
		logic rise;   // settled rise to high, arming rise included
		logic press;  // settled rise on an armed button
		logic hold;   // settled low poll that feeds the hold counter
	} lane_ev_t;

endpackage
`default_nettype wire

>>> design/bda_lane.sv
// One button lane: raw edge timestamp, debounce compare, stable level and arming.
// Depends on bda_pkg for widths and the lane event struct.
`timescale 1ns / 1ps
`default_nettype none
module bda_lane (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            adv,
	input  wire logic                            raw,
	input  wire logic [bda_pkg::TIME_W-1:0]      now_ms,
	input  wire logic [bda_pkg::DEB_W-1:0]       debounce_ms,
	output bda_pkg::lane_ev_t                    ev
);

	logic                         prev_q;
	logic                         stable_q;
	logic                         armed_q;
	logic [bda_pkg::TIME_W-1:0]   change_q;
	logic [bda_pkg::TIME_W-1:0]   elapsed;
	logic                         settled;

	assign elapsed = now_ms - change_q;
	assign settled = (raw == prev_q) &&
		(elapsed > {{(bda_pkg::TIME_W-bda_pkg::DEB_W){1'b0}}, debounce_ms});

	always_comb begin
		ev.rise  = settled && raw && !stable_q;
		ev.press = settled && raw && !stable_q && armed_q;
		ev.hold  = settled && !raw && !stable_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= 1'b0;
			stable_q <= 1'b0;
			armed_q  <= 1'b0;
			change_q <= '0;
		end else if (adv) begin
			prev_q <= raw;
			if (raw != prev_q) begin
				change_q <= now_ms;
			end
			if (settled && (raw != stable_q)) begin
				stable_q <= raw;
			end
			if (ev.rise) begin
				armed_q <= 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

>>> design/bda_repeat.sv
// Shared hold counter, repeat level and accel flag, walked over buttons in order.
// Depends on bda_pkg for widths, reset values and the lane event struct.
`timescale 1ns / 1ps
`default_nettype none
module bda_repeat #(
	parameter int NUM_BUTTONS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          adv,
	input  wire bda_pkg::lane_ev_t             ev [NUM_BUTTONS],
	input  wire logic [bda_pkg::HOLD_W-1:0]    hold_limit,
	input  wire logic [bda_pkg::LVL_W-1:0]     max_level,
	output logic [NUM_BUTTONS-1:0]             rep_flags,
	output logic                               rep_any,
	output logic                               accel_nxt,
	output logic [bda_pkg::LVL_W-1:0]          level_nxt
);

	logic [bda_pkg::HOLD_W-1:0] hold_q;
	logic [bda_pkg::LVL_W-1:0]  level_q;
	logic                       accel_q;
	logic [bda_pkg::HOLD_W-1:0] hold_nxt;
	logic [bda_pkg::LVL_W-1:0]  top;

	assign top = (max_level == '0) ? bda_pkg::LVL_W'(1) : max_level;

	always_comb begin
		logic [bda_pkg::HOLD_W-1:0] hc;
		logic [bda_pkg::LVL_W:0]    lv;
		hc        = hold_q;
		lv        = {1'b0, level_q};
		accel_nxt = accel_q;
		rep_flags = '0;
		for (int i = 0; i < NUM_BUTTONS; i++) begin
			if (ev[i].rise) begin
				hc = '0;
			end else if (ev[i].hold) begin
				if (hc != bda_pkg::HOLD_TOP) begin
					hc = hc + 1'b1;
				end
				if (hc > hold_limit) begin
					rep_flags[i] = 1'b1;
					hc           = '0;
					accel_nxt    = 1'b1;
					lv           = lv + 1'b1;
					if (lv > {1'b0, top}) begin
						lv = {1'b0, top};
					end
				end
			end
		end
		hold_nxt  = hc;
		level_nxt = lv[bda_pkg::LVL_W-1:0];
		rep_any   = |rep_flags;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q  <= '0;
			level_q <= bda_pkg::LEVEL_RESET;
			accel_q <= 1'b0;
		end else if (adv) begin
			hold_q  <= hold_nxt;
			level_q <= level_nxt;
			accel_q <= accel_nxt;
		end
	end

endmodule
`default_nettype wire

>>> design/button_debounce_autorepeat.sv
// Button debounce with press events and shared auto-repeat: top level.
// Depends on bda_pkg, bda_lane and bda_repeat.
//
// Usage:
//   Poll channel: in_valid / in_stall with now_ms and button_levels. One
//   beat is one poll of all buttons.
//   Result channel: out_valid / out_stall with press_flags, beep,
//   accel_active and speed_level, one result beat per poll beat.
//   Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data;
//   cfg_ready is always high. Write only while no poll is in flight.
// Pipeline: input register, then result register, from poll beat to result
//   beat. Throughput: one poll per cycle while the result is not stalled;
//   the per-button debounce compares run in parallel and the shared hold
//   counter is walked through all buttons within the same cycle.
// Reset: all button history, the hold counter and accel clear, the repeat
//   level goes to one, registers take their default values.
// Stall: a stalled result holds; the input register keeps taking a poll
//   until both stages are full, then in_stall rises.
`timescale 1ns / 1ps
`default_nettype none
module button_debounce_autorepeat #(
	parameter int NUM_BUTTONS = 4
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic [bda_pkg::TIME_W-1:0]        now_ms,
	input  wire logic [NUM_BUTTONS-1:0]            button_levels,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [NUM_BUTTONS-1:0]                 press_flags,
	output logic                                   beep,
	output logic                                   accel_active,
	output logic [bda_pkg::LVL_W-1:0]              speed_level,
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [bda_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [bda_pkg::CFG_DAT_W-1:0]     cfg_data
);

	logic                          valid_s1;
	logic [bda_pkg::TIME_W-1:0]    now_s1;
	logic [NUM_BUTTONS-1:0]        levels_s1;
	logic                          adv;

	logic [bda_pkg::DEB_W-1:0]     debounce_q;
	logic [bda_pkg::HOLD_W-1:0]    hold_limit_q;
	logic [bda_pkg::LVL_W-1:0]     max_level_q;

	bda_pkg::lane_ev_t             ev [NUM_BUTTONS];
	logic [NUM_BUTTONS-1:0]        press_vec;
	logic [NUM_BUTTONS-1:0]        rise_vec;
	logic [NUM_BUTTONS-1:0]        rep_flags;
	logic                          rep_any;
	logic                          accel_nxt;
	logic [bda_pkg::LVL_W-1:0]     level_nxt;

	logic                          out_valid_q;
	logic [NUM_BUTTONS-1:0]        flags_q;
	logic                          beep_q;
	logic                          accel_q;
	logic [bda_pkg::LVL_W-1:0]     level_q;

	assign adv       = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && out_valid_q && out_stall;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q   <= bda_pkg::DEB_RESET;
			hold_limit_q <= bda_pkg::HOLD_RESET;
			max_level_q  <= bda_pkg::MAXLV_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (bda_pkg::cfg_idx_t'(cfg_index))
				bda_pkg::CFG_DEBOUNCE: begin
					debounce_q <= cfg_data[bda_pkg::DEB_W-1:0];
				end
				bda_pkg::CFG_HOLD: begin
					hold_limit_q <= cfg_data[bda_pkg::HOLD_W-1:0];
				end
				bda_pkg::CFG_MAX_LEVEL: begin
					max_level_q <= cfg_data[bda_pkg::LVL_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			now_s1    <= now_ms;
			levels_s1 <= button_levels;
		end
	end

	for (genvar g = 0; g < NUM_BUTTONS; g++) begin : g_lane
		bda_lane u_lane (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.raw         (levels_s1[g]),
			.now_ms      (now_s1),
			.debounce_ms (debounce_q),
			.ev          (ev[g])
		);
		assign press_vec[g] = ev[g].press;
		assign rise_vec[g]  = ev[g].rise;
	end

	bda_repeat #(
		.NUM_BUTTONS (NUM_BUTTONS)
	) u_repeat (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.ev         (ev),
		.hold_limit (hold_limit_q),
		.max_level  (max_level_q),
		.rep_flags  (rep_flags),
		.rep_any    (rep_any),
		.accel_nxt  (accel_nxt),
		.level_nxt  (level_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || !out_stall) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			flags_q <= press_vec | rep_flags;
			beep_q  <= (|rise_vec) || rep_any;
			accel_q <= accel_nxt;
			level_q <= level_nxt;
		end
	end

	assign out_valid    = out_valid_q;
	assign press_flags  = flags_q;
	assign beep         = beep_q;
	assign accel_active = accel_q;
	assign speed_level  = level_q;

endmodule
`default_nettype wire

>>> design/bda_chk.sv
// Port-level assertions for button_debounce_autorepeat, attached by bind.
// Depends on bda_pkg for widths; sees only the top level's ports.
`timescale 1ns / 1ps
`default_nettype none
module bda_chk #(
	parameter int NUM_BUTTONS = 4
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         out_valid,
	input wire logic                         out_stall,
	input wire logic [NUM_BUTTONS-1:0]       press_flags,
	input wire logic                         beep,
	input wire logic                         accel_active,
	input wire logic [bda_pkg::LVL_W-1:0]    speed_level
);

	a_flags_beep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (press_flags != '0) |-> beep)
		else $error("press flag without beep");

	a_level_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (speed_level != '0))
		else $error("speed level is zero");

	a_level_needs_accel: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !accel_active |-> (speed_level == bda_pkg::LEVEL_RESET))
		else $error("level moved without a repeat");

	a_hold_beat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(press_flags) && $stable(beep)
			&& $stable(accel_active) && $stable(speed_level))
		else $error("stalled result beat changed");

endmodule

bind button_debounce_autorepeat bda_chk #(
	.NUM_BUTTONS (NUM_BUTTONS)
) u_bda_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_stall    (out_stall),
	.press_flags  (press_flags),
	.beep         (beep),
	.accel_active (accel_active),
	.speed_level  (speed_level)
);
`default_nettype wire
